/* hdl/column_post_picture_decoder_top_defines.svh */
`ifndef COLUMN_POST_PICTURE_DECODER_TOP_DEFINES_SVH
`define COLUMN_POST_PICTURE_DECODER_TOP_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define CPPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// implication whose property is checked in the clock after cond holds
`define CPPD_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (prop)) else $error(msg);

`endif

/* hdl/cppd_pkg.sv */
`default_nettype none

package cppd_pkg;

    // palette and picture limits
    localparam int PAL_ENTRIES = 256;
    localparam int PAL_AW      = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;
    localparam logic [8:0]  PAL_LIMIT   = 9'(PAL_ENTRIES);
    localparam logic [12:0] MAX_DIM     = 13'd4096;
    localparam logic [12:0] HEIGHT_RST  = 13'd4096;
    localparam logic [7:0]  END_MARK    = 8'hFF;
    localparam logic [7:0]  ALPHA_OPQ   = 8'hFF;

    // queue sizes
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

    // item mode and result kind codes
    localparam logic MODE_PAL_WR = 1'b0;
    localparam logic MODE_DATA   = 1'b1;
    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_END    = 1'b1;

    typedef struct packed {
        logic        mode;
        logic        column_start;
        logic [11:0] column_index;
        logic [7:0]  data_byte;
        logic [7:0]  palette_index;
        logic [23:0] palette_color;
    } t_in;

    typedef struct packed {
        logic        kind;
        logic [11:0] pixel_column;
        logic [8:0]  pixel_row;
        logic [31:0] color_argb;
    } t_out;

    // work handed from the parser to the palette side
    typedef enum logic [1:0] {
        OP_PAL_WR  = 2'd0,
        OP_PIXEL   = 2'd1,
        OP_COL_END = 2'd2
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [11:0] column;
        logic [8:0]  row;
        logic [7:0]  index;
        logic [23:0] color;
    } t_cmd;

    // parser phases
    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_TOP     = 6'b000010,
        PH_LEN     = 6'b000100,
        PH_PREPAD  = 6'b001000,
        PH_PIXELS  = 6'b010000,
        PH_POSTPAD = 6'b100000
    } t_phase;

endpackage

`default_nettype wire

/* hdl/cppd_front.sv */
`default_nettype none

module cppd_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_accept,
    input  cppd_pkg::t_in       i_item,
    input  wire                 i_cfg_we,
    input  wire [12:0]          i_cfg_wdata,
    output logic                o_cmd_vld,
    output cppd_pkg::t_cmd      o_cmd
);
    import cppd_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_top, n_top;
    logic [7:0]  r_left, n_left;
    logic [7:0]  r_pos, n_pos;
    logic [11:0] r_col, n_col;
    logic [12:0] r_height;

    t_phase      cur_phase;
    logic [7:0]  cur_top, cur_left, cur_pos, left_dec;
    logic [11:0] cur_col;
    logic [8:0]  row;
    logic [12:0] height_lim;

    // height register, clamped on use
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            r_height <= i_cfg_wdata;
        end
    end

    assign height_lim = (r_height > MAX_DIM) ? MAX_DIM : r_height;

    // start of column restarts the parser before the byte is taken
    assign cur_phase = i_item.column_start ? PH_TOP : r_phase;
    assign cur_top   = i_item.column_start ? 8'd0 : r_top;
    assign cur_left  = i_item.column_start ? 8'd0 : r_left;
    assign cur_pos   = i_item.column_start ? 8'd0 : r_pos;
    assign cur_col   = i_item.column_start ? i_item.column_index : r_col;
    assign row       = {1'b0, cur_top} + {1'b0, cur_pos};
    assign left_dec  = cur_left - 8'd1;

    // parse one byte and classify it
    always_comb begin
        n_phase   = r_phase;
        n_top     = r_top;
        n_left    = r_left;
        n_pos     = r_pos;
        n_col     = r_col;
        o_cmd_vld = 1'b0;
        o_cmd     = '{op: OP_PAL_WR, column: cur_col, row: row,
                      index: i_item.palette_index, color: i_item.palette_color};
        if (i_accept) begin
            if (i_item.mode == MODE_PAL_WR) begin
                o_cmd_vld = 1'b1;
            end else begin
                n_phase = cur_phase;
                n_top   = cur_top;
                n_left  = cur_left;
                n_pos   = cur_pos;
                n_col   = cur_col;
                unique case (cur_phase)
                    PH_TOP: begin
                        if (i_item.data_byte == END_MARK) begin
                            n_phase   = PH_IDLE;
                            o_cmd_vld = 1'b1;
                            o_cmd.op  = OP_COL_END;
                            o_cmd.row = 9'd0;
                        end else begin
                            n_top   = i_item.data_byte;
                            n_phase = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        n_left  = i_item.data_byte;
                        n_pos   = 8'd0;
                        n_phase = PH_PREPAD;
                    end
                    PH_PREPAD: begin
                        n_phase = (cur_left == 8'd0) ? PH_POSTPAD : PH_PIXELS;
                    end
                    PH_PIXELS: begin
                        n_pos  = cur_pos + 8'd1;
                        n_left = left_dec;
                        if (left_dec == 8'd0) begin
                            n_phase = PH_POSTPAD;
                        end
                        if ({4'd0, row} < height_lim) begin
                            o_cmd_vld   = 1'b1;
                            o_cmd.op    = OP_PIXEL;
                            o_cmd.index = i_item.data_byte;
                        end
                    end
                    PH_POSTPAD: begin
                        n_phase = PH_TOP;
                    end
                    PH_IDLE: begin
                        n_phase = PH_IDLE;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_top   <= 8'd0;
            r_left  <= 8'd0;
            r_pos   <= 8'd0;
            r_col   <= 12'd0;
        end else begin
            r_phase <= n_phase;
            r_top   <= n_top;
            r_left  <= n_left;
            r_pos   <= n_pos;
            r_col   <= n_col;
        end
    end

endmodule

`default_nettype wire

/* hdl/cppd_cmdq.sv */
`default_nettype none

module cppd_cmdq (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_wr,
    input  cppd_pkg::t_cmd      i_wdata,
    output logic                o_full,
    input  wire                 i_rd,
    output logic                o_empty,
    output cppd_pkg::t_cmd      o_rdata
);
    import cppd_pkg::*;

    t_cmd                 r_mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]   r_wp, r_rp;
    logic [CMDQ_CW-1:0]   r_cnt, n_cnt;
    logic                 wr_ok, rd_ok;

    assign o_full  = (r_cnt == CMDQ_CW'(CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;

    // occupancy
    always_comb begin
        n_cnt = r_cnt;
        if (wr_ok && !rd_ok) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_ok && !wr_ok) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (wr_ok) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd_ok) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

/* hdl/cppd_back.sv */
`default_nettype none

`include "column_post_picture_decoder_top_defines.svh"

module cppd_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_q_empty,
    input  cppd_pkg::t_cmd      i_q_cmd,
    output logic                o_q_pop,
    output logic                o_empty,
    input  wire                 i_pop,
    output cppd_pkg::t_out      o_result
);
    import cppd_pkg::*;

    localparam logic [OUTQ_CW:0] OUTQ_LIM = (OUTQ_CW + 1)'(OUTQ_DEPTH);

    // palette memory with a valid bit per entry
    logic [23:0]            r_pal [PAL_ENTRIES];
    logic [PAL_ENTRIES-1:0] r_pal_vld;

    // read stage
    logic                   r_b_vld;
    logic                   r_b_kind;
    logic                   r_b_hit;
    logic [11:0]            r_b_col;
    logic [8:0]             r_b_row;
    logic [23:0]            r_b_rgb;

    // result queue
    t_out                   r_oq [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0]     r_owp, r_orp;
    logic [OUTQ_CW-1:0]     r_ocnt, n_ocnt;

    logic                   issue, is_wr, is_res, pal_ok, out_rd;
    logic [PAL_AW-1:0]      pal_a;
    t_out                   b_res;

    // issue a command when the queue holds one; a pixel or column end also needs room on the result side
    assign is_wr  = (i_q_cmd.op == OP_PAL_WR);
    assign is_res = !is_wr;
    assign issue  = !i_q_empty &&
                    (is_wr || (({1'b0, r_ocnt} + (OUTQ_CW + 1)'(r_b_vld)) < OUTQ_LIM));
    assign o_q_pop = issue;
    assign pal_ok  = ({1'b0, i_q_cmd.index} < PAL_LIMIT);
    assign pal_a   = i_q_cmd.index[PAL_AW-1:0];

    // palette write and registered read
    always_ff @(posedge i_clk) begin
        if (issue && is_wr && pal_ok) begin
            r_pal[pal_a] <= i_q_cmd.color;
        end
        if (issue) begin
            r_b_rgb  <= r_pal[pal_a];
            r_b_hit  <= pal_ok && r_pal_vld[pal_a] && (i_q_cmd.op == OP_PIXEL);
            r_b_kind <= (i_q_cmd.op == OP_COL_END) ? KIND_END : KIND_PIXEL;
            r_b_col  <= i_q_cmd.column;
            r_b_row  <= i_q_cmd.row;
        end
    end

    // valid bits and read stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_vld <= '0;
            r_b_vld   <= 1'b0;
        end else begin
            r_b_vld <= issue && is_res;
            if (issue && is_wr && pal_ok) begin
                r_pal_vld[pal_a] <= 1'b1;
            end
        end
    end

    // build the result
    always_comb begin
        b_res.kind         = r_b_kind;
        b_res.pixel_column = r_b_col;
        b_res.pixel_row    = r_b_row;
        if (r_b_kind == KIND_END) begin
            b_res.color_argb = 32'd0;
        end else begin
            b_res.color_argb = {ALPHA_OPQ, r_b_hit ? r_b_rgb : 24'd0};
        end
    end

    // result queue
    assign o_empty  = (r_ocnt == '0);
    assign o_result = r_oq[r_orp];
    assign out_rd   = i_pop && !o_empty;

    always_comb begin
        n_ocnt = r_ocnt;
        if (r_b_vld && !out_rd) begin
            n_ocnt = r_ocnt + 1'b1;
        end else if (out_rd && !r_b_vld) begin
            n_ocnt = r_ocnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            r_ocnt <= n_ocnt;
            if (r_b_vld) begin
                r_owp <= r_owp + 1'b1;
            end
            if (out_rd) begin
                r_orp <= r_orp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_vld) begin
            r_oq[r_owp] <= b_res;
        end
    end

    // checks
    `CPPD_ASSERT(a_outq_bound, r_ocnt <= OUTQ_CW'(OUTQ_DEPTH), "result queue overflow")
    `CPPD_ASSERT(a_outq_room, !r_b_vld || (r_ocnt != OUTQ_CW'(OUTQ_DEPTH)), "full queue written")
    `CPPD_ASSERT_NEXT(a_res_staged, issue && is_res, r_b_vld, "issued result not staged")
    `CPPD_ASSERT_NEXT(a_wr_no_res, issue && is_wr, !r_b_vld, "palette write produced a result")

endmodule

`default_nettype wire

/* hdl/column_post_picture_decoder_top.sv */
`default_nettype none

// column post picture decoder
// input channel: push/full with an item struct; mode 0 writes a palette
// entry, mode 1 carries one byte of a column's post stream (column_start
// marks the first byte of a column and latches column_index)
// result channel: empty/pop; while empty is low o_result holds the oldest
// result, either a pixel (row, column, opaque argb) or a column end marker
// config: i_cfg_we/i_cfg_wdata write the picture height; rows at or past it
// are dropped, values above 4096 act as 4096
// path: an accepted item's command passes the command queue, the palette read register
// and the result queue before its result can be popped
// throughput: one item per cycle while full is low, bounded by the single palette port that
// serves both writes and pixel lookups one per cycle
// reset: parser idle until a column start, height 4096, palette reads zero
// until written; usable in the first cycle after reset
// a stalled receiver fills the result queue, then the command queue, then
// full rises; no item is lost
module column_post_picture_decoder_top (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 push,
    output logic                full,
    input  cppd_pkg::t_in       i_item,
    output logic                empty,
    input  wire                 pop,
    output cppd_pkg::t_out      o_result,
    input  wire                 i_cfg_we,
    input  wire [12:0]          i_cfg_wdata
);
    import cppd_pkg::*;

    logic  accept;
    logic  cmd_vld;
    t_cmd  cmd;
    logic  q_empty, q_pop;
    t_cmd  q_cmd;

    assign accept = push && !full;

    // parser
    cppd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cmd_vld   (cmd_vld),
        .o_cmd       (cmd)
    );

    // decoupling queue
    cppd_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_vld),
        .i_wdata (cmd),
        .o_full  (full),
        .i_rd    (q_pop),
        .o_empty (q_empty),
        .o_rdata (q_cmd)
    );

    // palette and results
    cppd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_result  (o_result)
    );

endmodule

`default_nettype wire
